// ----- rtl/phd_pkg.sv -----
// Shared types and constants for the packet header deframer.
`timescale 1ns / 1ps

package phd_pkg;

  // Header layout: type, source, destination, length word, reserved word
  localparam int unsigned HdrBytes = 11;
  localparam int unsigned LenPos   = 3;
  localparam int unsigned ResvPos  = 7;

  // Default depth of the result queue
  localparam int unsigned OutQDepth = 4;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StShort    = 2'd1,
    StMismatch = 2'd2
  } status_e;

  typedef enum logic {
    KindPayload = 1'b0,
    KindSummary = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  mtype;
    logic [7:0]  src_id;
    logic [7:0]  dst_id;
    logic [31:0] declared_len;
    logic [31:0] reserved_word;
    status_e     status;
    logic        last;
  } result_t;

  // Results raised by one accepted byte; payload goes out ahead of summary
  typedef struct packed {
    logic    pay_v;
    logic    sum_v;
    result_t pay;
    result_t sum;
  } push_t;

endpackage

// ----- rtl/phd_if.sv -----
// Valid/ready channel interfaces for the deframer's byte input and result output.
`timescale 1ns / 1ps

interface phd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       frame_end;

  modport source (output valid, output in_byte, output frame_end, input ready);
  modport sink   (input valid, input in_byte, input frame_end, output ready);
endinterface

interface phd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data;
  logic [7:0]  mtype;
  logic [7:0]  src_id;
  logic [7:0]  dst_id;
  logic [31:0] declared_len;
  logic [31:0] reserved_word;
  logic [1:0]  status;
  logic        last;

  modport source (
    output valid, output kind, output data, output mtype, output src_id,
    output dst_id, output declared_len, output reserved_word, output status,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input data, input mtype, input src_id,
    input dst_id, input declared_len, input reserved_word, input status,
    input last, output ready
  );
endinterface

// ----- rtl/phd_parse.sv -----
// Frame parser: header capture, payload count and end-of-frame status.
`timescale 1ns / 1ps

module phd_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     in_byte_i,
  input  logic           frame_end_i,
  output phd_pkg::push_t push_o
);
  import phd_pkg::*;

  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  src_q, src_d;
  logic [7:0]  dst_q, dst_d;
  logic [31:0] len_q, len_d;
  logic [31:0] resv_q, resv_d;
  logic [31:0] seen_q, seen_d;
  logic        excess_q, excess_d;
  logic [1:0]  len_sel, resv_sel;

  always_comb begin
    hdr_pos_d = hdr_pos_q;
    type_d    = type_q;
    src_d     = src_q;
    dst_d     = dst_q;
    len_d     = len_q;
    resv_d    = resv_q;
    seen_d    = seen_q;
    excess_d  = excess_q;

    // byte index within the length or reserved word, 0 is the top byte
    len_sel  = 2'(hdr_pos_q - 4'(LenPos));
    resv_sel = 2'(hdr_pos_q - 4'(ResvPos));

    push_o            = '0;
    push_o.pay.kind   = KindPayload;
    push_o.pay.data   = in_byte_i;
    push_o.sum.kind   = KindSummary;
    push_o.sum.status = StOk;
    push_o.sum.last   = 1'b1;

    if (accept_i) begin
      if (hdr_pos_q < 4'(HdrBytes)) begin
        // words arrive most significant byte first; each byte lands in its own lane,
        // so a header cut short leaves the missing low bytes at zero
        if (hdr_pos_q == 4'd0) begin
          type_d = in_byte_i;
        end else if (hdr_pos_q == 4'd1) begin
          src_d = in_byte_i;
        end else if (hdr_pos_q < 4'(LenPos)) begin
          dst_d = in_byte_i;
        end else if (hdr_pos_q < 4'(ResvPos)) begin
          len_d[{~len_sel, 3'b000} +: 8] = in_byte_i;
        end else begin
          resv_d[{~resv_sel, 3'b000} +: 8] = in_byte_i;
        end
        hdr_pos_d = hdr_pos_q + 4'd1;
      end else if (seen_q < len_q) begin
        push_o.pay_v = 1'b1;
        seen_d       = seen_q + 32'd1;
      end else begin
        excess_d = 1'b1;
      end

      if (frame_end_i) begin
        push_o.sum_v             = 1'b1;
        push_o.sum.mtype         = type_d;
        push_o.sum.src_id        = src_d;
        push_o.sum.dst_id        = dst_d;
        push_o.sum.declared_len  = len_d;
        push_o.sum.reserved_word = resv_d;
        if (hdr_pos_d < 4'(HdrBytes)) begin
          push_o.sum.status = StShort;
        end else if (excess_d || (seen_d != len_d)) begin
          push_o.sum.status = StMismatch;
        end else begin
          push_o.sum.status = StOk;
        end
        // clear down for the next frame
        hdr_pos_d = '0;
        type_d    = '0;
        src_d     = '0;
        dst_d     = '0;
        len_d     = '0;
        resv_d    = '0;
        seen_d    = '0;
        excess_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q <= '0;
      type_q    <= '0;
      src_q     <= '0;
      dst_q     <= '0;
      len_q     <= '0;
      resv_q    <= '0;
      seen_q    <= '0;
      excess_q  <= 1'b0;
    end else begin
      hdr_pos_q <= hdr_pos_d;
      type_q    <= type_d;
      src_q     <= src_d;
      dst_q     <= dst_d;
      len_q     <= len_d;
      resv_q    <= resv_d;
      seen_q    <= seen_d;
      excess_q  <= excess_d;
    end
  end

endmodule

// ----- rtl/phd_outq.sv -----
// Result queue: takes up to two results a cycle, hands out one per transaction.
`timescale 1ns / 1ps

module phd_outq #(
  parameter int unsigned Depth = phd_pkg::OutQDepth,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  phd_pkg::push_t   push_i,
  output logic             room_o,
  output logic [CntW-1:0]  count_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output phd_pkg::result_t out_o
);
  import phd_pkg::*;

  result_t         mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d, wptr_nx;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;
  logic [1:0]      push_n;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    r = (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign push_n      = {1'b0, push_i.pay_v} + {1'b0, push_i.sum_v};
  assign wptr_nx     = ptr_inc(wptr_q);
  assign out_valid_o = (count_q != '0);
  assign out_o       = mem_q[rptr_q];
  assign count_o     = count_q;
  // room for a full pair of results, judged from the registered fill only
  assign room_o      = (count_q <= CntW'(Depth - 2));

  always_comb begin
    count_d = count_q + CntW'(push_n) - CntW'(pop);
    rptr_d  = pop ? ptr_inc(rptr_q) : rptr_q;
    case (push_n)
      2'd1:    wptr_d = wptr_nx;
      2'd2:    wptr_d = ptr_inc(wptr_nx);
      default: wptr_d = wptr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i.pay_v) begin
      mem_q[wptr_q] <= push_i.pay;
    end
    if (push_i.sum_v) begin
      mem_q[push_i.pay_v ? wptr_nx : wptr_q] <= push_i.sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

endmodule

// ----- rtl/packet_header_deframer.sv -----
// Top level of the packet header deframer: byte input, parser and result queue.
//
// Usage
//   in_i  : one frame byte per transaction, frame_end high on the frame's final byte.
//   out_o : result transactions. kind 0 carries a payload byte in data; kind 1 is the
//           end-of-frame summary (header fields, status, last high).
//   The first 11 bytes of a frame are header; later bytes are forwarded as payload
//   while they fit the declared length, excess bytes are dropped and give status 2.
//   Payload is forwarded as it arrives; the consumer discards it on a bad status.
// Timing
//   A byte is parsed in the cycle it is taken; its results are in the queue at the
//   next edge, so out_o.valid rises in the cycle after the input transaction.
//   Throughput is one byte per cycle while in_i.ready is high. A final byte that also
//   carries payload makes two results, which the single output port drains in turn.
//   in_i.ready comes straight from the queue fill (room for two results), so it
//   never depends on out_o.ready in the same cycle.
// Reset
//   rst_ni clears the parser and empties the queue; the next byte starts a frame.
// Stall
//   While out_o.ready is low results wait in the queue; once it has no room for
//   two more, in_i.ready drops until the receiver takes results again.
`timescale 1ns / 1ps

module packet_header_deframer #(
  parameter int unsigned OutDepth = phd_pkg::OutQDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  phd_in_if.sink           in_i,
  phd_out_if.source        out_o
);
  import phd_pkg::*;

  localparam int unsigned CntW = $clog2(OutDepth + 1);

  logic            accept;
  push_t           push;
  result_t         res;
  logic [CntW-1:0] q_count;

  assign accept = in_i.valid && in_i.ready;

  phd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_i.in_byte),
    .frame_end_i (in_i.frame_end),
    .push_o      (push)
  );

  phd_outq #(
    .Depth (OutDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (in_i.ready),
    .count_o     (q_count),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  assign out_o.kind          = res.kind;
  assign out_o.data          = res.data;
  assign out_o.mtype         = res.mtype;
  assign out_o.src_id        = res.src_id;
  assign out_o.dst_id        = res.dst_id;
  assign out_o.declared_len  = res.declared_len;
  assign out_o.reserved_word = res.reserved_word;
  assign out_o.status        = res.status;
  assign out_o.last          = res.last;

  // results are raised only by an accepted byte
  a_push_needs_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.pay_v || push.sum_v) |-> accept)
    else $error("result pushed without an input transaction");

  // every final byte closes its frame with a summary
  a_end_gives_summary : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.frame_end) |-> push.sum_v)
    else $error("frame end without summary");

  // queue never overfills
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CntW'(OutDepth))
    else $error("result queue overflow");

  // a queued result stays visible until taken
  a_queue_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready && !push.pay_v && !push.sum_v)
      |=> (q_count == $past(q_count)))
    else $error("result queue lost an entry while stalled");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for packet_header_deframer: byte frames in, results scoreboarded.
`timescale 1ns / 1ps

module tb;
  import phd_pkg::*;

  localparam int unsigned RandBytes  = 1000;  // random part stops after this many bytes
  localparam int unsigned MaxGap     = 18;    // longest idle draw on either side
  localparam int unsigned HoldCycles = 150;   // long receiver hold-off
  localparam int unsigned MaxReports = 10;
  localparam int unsigned DrainWait  = 32;    // settle time once nothing is owed

  // Random frame shapes
  typedef enum int {
    FrameGood,      // payload count matches the declared length
    FrameShortPay,  // fewer payload bytes than declared
    FrameExcess,    // bytes beyond the declared length
    FrameShortHdr,  // frame ends inside the header
    FrameNoise      // random length word, a few bytes of payload
  } frame_shape_e;

  // Scoreboard: tracks the parser state, holds the results still owed and checks
  // each result transaction against the oldest one.
  class deframe_scoreboard;
    int unsigned hdr_cnt;
    logic [7:0]  type_q, src_q, dst_q;
    logic [31:0] len_q, resv_q, pay_cnt;
    bit          dropped;
    result_t     results_due[$];
    int unsigned mismatches, bytes_in, pay_seen, results_seen;
    int unsigned status_seen[3];

    function new();
      clear_frame();
    endfunction

    function void clear_frame();
      hdr_cnt = 0;
      type_q  = '0;
      src_q   = '0;
      dst_q   = '0;
      len_q   = '0;
      resv_q  = '0;
      pay_cnt = '0;
      dropped = 1'b0;
    endfunction

    // One accepted input transaction
    function void predict_byte(logic [7:0] b, logic fin);
      result_t r;
      status_e st;
      bytes_in++;
      if (hdr_cnt < HdrBytes) begin
        if (hdr_cnt == 0) type_q = b;
        else if (hdr_cnt == 1) src_q = b;
        else if (hdr_cnt == 2) dst_q = b;
        else if (hdr_cnt < ResvPos) len_q[8 * (ResvPos - 1 - hdr_cnt) +: 8] = b;
        else resv_q[8 * (HdrBytes - 1 - hdr_cnt) +: 8] = b;
        hdr_cnt++;
      end else if (pay_cnt < len_q) begin
        r = '0;
        r.kind = KindPayload;
        r.data = b;
        r.status = StOk;
        results_due = {results_due, r};
        pay_cnt++;
      end else begin
        dropped = 1'b1;
      end
      if (fin) begin
        if (hdr_cnt < HdrBytes) st = StShort;
        else if (dropped || pay_cnt != len_q) st = StMismatch;
        else st = StOk;
        r = '0;
        r.kind          = KindSummary;
        r.mtype         = type_q;
        r.src_id        = src_q;
        r.dst_id        = dst_q;
        r.declared_len  = len_q;
        r.reserved_word = resv_q;
        r.status        = st;
        r.last          = 1'b1;
        results_due = {results_due, r};
        clear_frame();
      end
    endfunction

    function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        if (mismatches < MaxReports)
          $display("tb: result %0d field %s expected %0h got %0h",
                   results_seen, name, want, got);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // One accepted result transaction
    function void check_result(result_t got);
      result_t want;
      bit      bad;
      results_seen++;
      if (results_due.size() == 0) begin
        if (mismatches < MaxReports)
          $display("tb: result %0d unexpected, kind %0h data %0h status %0h",
                   results_seen, got.kind, got.data, got.status);
        mismatches++;
        return;
      end
      want = results_due.pop_front();
      bad = 1'b0;
      bad |= field_differs("kind", want.kind, got.kind);
      bad |= field_differs("data", want.data, got.data);
      bad |= field_differs("mtype", want.mtype, got.mtype);
      bad |= field_differs("src_id", want.src_id, got.src_id);
      bad |= field_differs("dst_id", want.dst_id, got.dst_id);
      bad |= field_differs("declared_len", want.declared_len, got.declared_len);
      bad |= field_differs("reserved_word", want.reserved_word, got.reserved_word);
      bad |= field_differs("status", want.status, got.status);
      bad |= field_differs("last", want.last, got.last);
      if (bad) mismatches++;
      if (want.kind == KindPayload) pay_seen++;
      else if (want.status <= StMismatch) status_seen[want.status]++;
    endfunction
  endclass

  logic clk;
  logic rst_n;

  phd_in_if  in_if ();
  phd_out_if out_if ();

  packet_header_deframer DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  deframe_scoreboard sb;

  bit          tx_fast;      // sender offers back to back
  bit          rx_fast;      // receiver draws no random stalls
  bit          rx_hold_req;  // ask the receiver for one long hold-off
  int unsigned holds_done;
  int unsigned frames_sent;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Handshakes are judged at the falling edge: nothing the block drives moves
  // between there and the next rising edge, where the transaction completes.

  // Send one byte; returns at the rising edge that takes it.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(MaxGap, 0);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.in_byte   <= b;
    in_if.frame_end <= fin;
    do @(negedge clk); while (!in_if.ready);
    sb.predict_byte(b, fin);
    @(posedge clk);
  endtask

  // frame_end goes with the final byte; valid is left to the next byte's draw
  task automatic send_frame(input logic [7:0] fr[$]);
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
    frames_sent++;
  endtask

  task automatic send_random_frame();
    frame_shape_e shape;
    int unsigned  pick, n_pay, n_hdr;
    logic [31:0]  len, resv;
    logic [7:0]   fr[$];
    pick = $urandom_range(99, 0);
    if (pick < 55) shape = FrameGood;
    else if (pick < 67) shape = FrameShortPay;
    else if (pick < 79) shape = FrameExcess;
    else if (pick < 90) shape = FrameShortHdr;
    else shape = FrameNoise;
    // Mostly short payloads, now and then a longer one
    len = ($urandom_range(99, 0) < 85) ? $urandom_range(12, 0) : $urandom_range(40, 13);
    resv = $urandom;
    case (shape)
      FrameGood: n_pay = len;
      FrameShortPay: begin
        len   = len + 1;
        n_pay = $urandom_range(len - 1, 0);
      end
      FrameExcess: n_pay = len + $urandom_range(3, 1);
      FrameNoise: begin
        len   = $urandom;
        n_pay = $urandom_range(6, 0);
      end
      default: n_pay = 0;
    endcase
    fr = {fr, 8'($urandom_range(255, 0))};
    fr = {fr, 8'($urandom_range(255, 0))};
    fr = {fr, 8'($urandom_range(255, 0))};
    for (int i = 3; i >= 0; i--) fr = {fr, len[8 * i +: 8]};
    for (int i = 3; i >= 0; i--) fr = {fr, resv[8 * i +: 8]};
    if (shape == FrameShortHdr) begin
      n_hdr = $urandom_range(HdrBytes - 1, 1);
      while (fr.size() > n_hdr) void'(fr.pop_back());
    end
    repeat (n_pay) fr = {fr, 8'($urandom_range(255, 0))};
    send_frame(fr);
  endtask

  // Receiver: a fresh stall draw before each result transaction
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        stall = HoldCycles;
        rx_hold_req = 1'b0;
        holds_done++;
      end else begin
        stall = rx_fast ? 0 : $urandom_range(MaxGap, 0);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(negedge clk); while (!out_if.valid);
      @(posedge clk);
    end
  end

  // Result monitor
  always @(negedge clk) begin
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.kind          = kind_e'(out_if.kind);
      got.data          = out_if.data;
      got.mtype         = out_if.mtype;
      got.src_id        = out_if.src_id;
      got.dst_id        = out_if.dst_id;
      got.declared_len  = out_if.declared_len;
      got.reserved_word = out_if.reserved_word;
      got.status        = status_e'(out_if.status);
      got.last          = out_if.last;
      sb.check_result(got);
    end
  end

  // Generous bound: over ten times the slowest legal run
  initial begin
    #8_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    int unsigned fast_frames;
    sb = new();
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.in_byte   <= '0;
    in_if.frame_end <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-byte frame, payload on the final byte with extreme header
    // values, and a dropped byte past a zero length.
    send_frame('{8'hFF});
    send_frame('{8'hFF, 8'h00, 8'hA5, 8'h00, 8'h00, 8'h00, 8'h01,
                 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00});
    send_frame('{8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF});

    // Random frames with idling drawn per frame; long receiver hold-offs asked at frames 20
    // and 70 while the sender keeps pushing, so the result queue backs up.
    fast_frames = 0;
    while (sb.bytes_in < RandBytes + 25) begin
      if (frames_sent == 20 || frames_sent == 70) begin
        rx_hold_req = 1'b1;
        fast_frames = 6;
      end
      case ($urandom_range(3, 0))
        0: begin tx_fast = 1'b0; rx_fast = 1'b0; end
        1: begin tx_fast = 1'b1; rx_fast = 1'b1; end
        2: begin tx_fast = 1'b1; rx_fast = 1'b0; end
        default: begin tx_fast = 1'b0; rx_fast = 1'b1; end
      endcase
      if (fast_frames > 0) begin
        tx_fast = 1'b1;
        fast_frames--;
      end
      send_random_frame();
    end
    in_if.valid <= 1'b0;

    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("tb: %0d frames, %0d bytes in, %0d receiver hold-offs",
             frames_sent, sb.bytes_in, holds_done);
    $display("tb: %0d payload results, summaries ok %0d short %0d mismatch %0d, %0d bad",
             sb.pay_seen, sb.status_seen[StOk], sb.status_seen[StShort],
             sb.status_seen[StMismatch], sb.mismatches);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/phd_pkg.sv
rtl/phd_if.sv
rtl/phd_parse.sv
rtl/phd_outq.sv
rtl/packet_header_deframer.sv
sim/tb.sv
